>>> design/hsv_pkg.sv
package hsv_pkg;

  localparam int LEVEL_W = 8;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 24;
  localparam int NUM_W   = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  // 255 * 65536, the common denominator of q and t
  localparam logic [PROD_W-1:0]  DEN_QT     = 24'hFF0000;
  localparam logic [FRAC_W:0]    FRAC_ONE   = 17'h10000;

  typedef logic [2:0] sector_t;

  localparam sector_t SECT_RED_YEL = 3'd0;
  localparam sector_t SECT_YEL_GRN = 3'd1;
  localparam sector_t SECT_GRN_CYN = 3'd2;
  localparam sector_t SECT_CYN_BLU = 3'd3;
  localparam sector_t SECT_BLU_MAG = 3'd4;

  // after hue split and saturation products
  typedef struct packed {
    logic                valid;
    sector_t             sector;
    logic [LEVEL_W-1:0]  v;
    logic [LEVEL_W-1:0]  ps;
    logic [PROD_W-1:0]   sq;
    logic [PROD_W-1:0]   st;
  } split_t;

  // scaled levels before the divide by 255
  typedef struct packed {
    logic                valid;
    sector_t             sector;
    logic [LEVEL_W-1:0]  v;
    logic [FRAC_W-1:0]   mp;
    logic [FRAC_W-1:0]   mq;
    logic [FRAC_W-1:0]   mt;
  } level_t;

endpackage

>>> design/hsv_split.sv
module hsv_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [15:0]          hue,
  input  logic [7:0]           saturation,
  input  logic [7:0]           brightness,
  output hsv_pkg::split_t      split
);
  import hsv_pkg::*;

  logic [18:0]       x;
  logic [FRAC_W-1:0] f;
  logic [FRAC_W:0]   g;
  logic [PROD_W:0]   st_full;

  // hue * 6 as shift and add
  assign x       = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
  assign f       = x[FRAC_W-1:0];
  assign g       = FRAC_ONE - {1'b0, f};
  // s * (65536 - f) never exceeds 255 * 65536, top bit is always zero
  assign st_full = {17'd0, saturation} * {8'd0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      split.valid <= 1'b0;
    end else begin
      split.valid <= in_valid;
    end
    split.sector <= x[18:16];
    split.v      <= brightness;
    split.ps     <= LEVEL_FULL - saturation;
    split.sq     <= {16'd0, saturation} * {8'd0, f};
    split.st     <= st_full[PROD_W-1:0];
  end

endmodule

>>> design/hsv_level.sv
module hsv_level (
  input  logic             clk,
  input  logic             rst,
  input  hsv_pkg::split_t  split,
  output hsv_pkg::level_t  level
);
  import hsv_pkg::*;

  logic [PROD_W-1:0] aq;
  logic [PROD_W-1:0] at;
  logic [NUM_W-1:0]  nq;
  logic [NUM_W-1:0]  nt;
  logic [15:0]       np;

  assign aq = DEN_QT - split.sq;
  assign at = DEN_QT - split.st;
  assign nq = {24'd0, split.v} * {8'd0, aq};
  assign nt = {24'd0, split.v} * {8'd0, at};
  assign np = {8'd0, split.v} * {8'd0, split.ps};

  // floor(n / 65536) first for q and t, p is taken unscaled, the divide by 255 follows
  always_ff @(posedge clk) begin
    if (rst) begin
      level.valid <= 1'b0;
    end else begin
      level.valid <= split.valid;
    end
    level.sector <= split.sector;
    level.v      <= split.v;
    level.mp     <= np;
    level.mq     <= nq[NUM_W-1:FRAC_W];
    level.mt     <= nt[NUM_W-1:FRAC_W];
  end

endmodule

>>> design/hsv_div255.sv
module hsv_div255 (
  input  logic        clk,
  input  logic [15:0] m,
  output logic [7:0]  quo
);

  logic [23:0] m257;
  logic [7:0]  est;
  logic [15:0] m_q;
  logic [15:0] rem;

  // m * 257 / 65536 undershoots m / 255 by less than one
  assign m257 = {8'd0, m} + {m, 8'd0};

  always_ff @(posedge clk) begin
    est <= m257[23:16];
    m_q <= m;
  end

  assign rem = m_q - ({est, 8'd0} - {8'd0, est});
  assign quo = (rem >= 16'd255) ? est + 8'd1 : est;

endmodule

>>> design/hsv_to_rgb_converter_top.sv
// channel | dir | signals                         | beat
// --------+-----+---------------------------------+-------------------------
// pixel   | in  | hue, saturation, brightness     | start && !busy
// color   | out | red, green, blue                | done, one cycle only
//
// one pixel per clock
// stages: hue split and saturation products, value products, reciprocal
// estimate of the divide by 255, correction and channel pick
// busy is never raised since every stage advances each cycle
// the receiver cannot stall, so results are never held
// synchronous reset clears the valid bits of all stages
module hsv_to_rgb_converter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [15:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       done,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import hsv_pkg::*;

  split_t  split;
  level_t  level;

  // sector and value ride alongside the divider stage
  logic    div_valid;
  sector_t div_sector;
  logic [LEVEL_W-1:0] div_v;

  logic [LEVEL_W-1:0] p;
  logic [LEVEL_W-1:0] q;
  logic [LEVEL_W-1:0] t;
  logic [LEVEL_W-1:0] red_next;
  logic [LEVEL_W-1:0] green_next;
  logic [LEVEL_W-1:0] blue_next;

  // fully pipelined, a new beat is taken every cycle
  assign busy = 1'b0;

  hsv_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .split      (split)
  );

  hsv_level u_level (
    .clk   (clk),
    .rst   (rst),
    .split (split),
    .level (level)
  );

  hsv_div255 u_div_p (.clk(clk), .m(level.mp), .quo(p));
  hsv_div255 u_div_q (.clk(clk), .m(level.mq), .quo(q));
  hsv_div255 u_div_t (.clk(clk), .m(level.mt), .quo(t));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else begin
      div_valid <= level.valid;
    end
  end

  always_ff @(posedge clk) begin
    div_sector <= level.sector;
    div_v      <= level.v;
  end

  // channel pick by sector, the last sector takes the default arm
  always_comb begin
    case (div_sector)
      SECT_RED_YEL: begin
        red_next = div_v; green_next = t;     blue_next = p;
      end
      SECT_YEL_GRN: begin
        red_next = q;     green_next = div_v; blue_next = p;
      end
      SECT_GRN_CYN: begin
        red_next = p;     green_next = div_v; blue_next = t;
      end
      SECT_CYN_BLU: begin
        red_next = p;     green_next = q;     blue_next = div_v;
      end
      SECT_BLU_MAG: begin
        red_next = t;     green_next = p;     blue_next = div_v;
      end
      default: begin
        red_next = div_v; green_next = p;     blue_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  // every accepted pixel comes out as a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted pixel did not come out after four cycles");

  // no result without a matching start
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result strobe without an accepted pixel");

  // one channel always carries the value
  a_max_channel: assert property (@(posedge clk) disable iff (rst)
    done |-> (red == $past(brightness, 4) || green == $past(brightness, 4) ||
              blue == $past(brightness, 4)))
    else $error("no channel equals the value");

  // zero saturation gives grey
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && saturation == 8'd0) |-> ##4
      (red == $past(brightness, 4) && green == red && blue == red))
    else $error("zero saturation did not give grey");

endmodule
